FILE: design/ilst_pkg.sv
package ilst_pkg;

   localparam int MODE_W = 2;
   localparam int POS_W  = 10;
   localparam int VAL_W  = 32;
   localparam int STAT_W = 2;
   localparam int LEN_W  = 9;

   localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
   localparam logic [MODE_W-1:0] MODE_DELETE = 2'd1;
   localparam logic [MODE_W-1:0] MODE_READ   = 2'd2;

   localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
   localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
   localparam logic [STAT_W-1:0] ST_RANGE = 2'd2;

   typedef struct packed {
      logic              accept;
      logic              ptr_load_up;
      logic              ptr_load_dn;
      logic              shift_up;
      logic              shift_dn;
      logic              rd_direct;
      logic              put;
      logic              cnt_inc;
      logic              cnt_dec;
      logic              rsp_load;
      logic [STAT_W-1:0] rsp_status;
      logic              rsp_use_data;
   } ilst_cmd_type;

   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic              full;
      logic              empty;
      logic              beyond;
      logic              last;
      logic              ptr_at_pos;
      logic              ptr_at_end;
      logic              rsp_busy;
   } ilst_stat_type;

endpackage

FILE: design/ilst_if.sv
interface ilst_req_if import ilst_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic [MODE_W-1:0]       mode;
   logic [POS_W-1:0]        position;
   logic signed [VAL_W-1:0] value_in;

   modport source (output valid, mode, position, value_in, input ready);
   modport sink (input valid, mode, position, value_in, output ready);
endinterface

interface ilst_rsp_if import ilst_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic signed [VAL_W-1:0] value_out;
   logic [STAT_W-1:0]       status;
   logic [LEN_W-1:0]        length;

   modport source (output valid, value_out, status, length, input ready);
   modport sink (input valid, value_out, status, length, output ready);
endinterface

FILE: design/ilst_ctrl.sv
module ilst_ctrl import ilst_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  ilst_stat_type stat,
   output ilst_cmd_type  cmd
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_DECODE,
      S_UP,
      S_UP_FLUSH,
      S_PUT,
      S_DOWN,
      S_DN_FLUSH,
      S_RD,
      S_FINISH
   } state_type;

   state_type         state_ff, state_in;
   logic [STAT_W-1:0] status_ff, status_in;
   logic              use_data_ff, use_data_in;

   always_comb begin
      cmd         = '0;
      state_in    = state_ff;
      status_in   = status_ff;
      use_data_in = use_data_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = S_DECODE;
            end
         end
         S_DECODE: begin
            use_data_in = 1'b0;
            status_in   = ST_OK;
            unique case (stat.mode)
               MODE_INSERT: begin
                  if (stat.full) begin
                     status_in = ST_FULL;
                     state_in  = S_FINISH;
                  end else if (stat.beyond) begin
                     state_in = S_PUT;
                  end else begin
                     cmd.ptr_load_up = 1'b1;
                     state_in        = S_UP;
                  end
               end
               MODE_DELETE: begin
                  if (stat.beyond) begin
                     status_in = ST_RANGE;
                     state_in  = S_FINISH;
                  end else if (stat.last) begin
                     cmd.cnt_dec = 1'b1;
                     state_in    = S_FINISH;
                  end else begin
                     cmd.ptr_load_dn = 1'b1;
                     state_in        = S_DOWN;
                  end
               end
               MODE_READ: begin
                  if (stat.empty) begin
                     status_in = ST_RANGE;
                     state_in  = S_FINISH;
                  end else begin
                     cmd.rd_direct = 1'b1;
                     use_data_in   = 1'b1;
                     state_in      = S_RD;
                  end
               end
               default: begin
                  status_in = ST_RANGE;
                  state_in  = S_FINISH;
               end
            endcase
         end
         S_UP: begin
            cmd.shift_up = 1'b1;
            if (stat.ptr_at_pos) begin
               state_in = S_UP_FLUSH;
            end
         end
         S_UP_FLUSH: begin
            state_in = S_PUT;
         end
         S_PUT: begin
            cmd.put     = 1'b1;
            cmd.cnt_inc = 1'b1;
            state_in    = S_FINISH;
         end
         S_DOWN: begin
            cmd.shift_dn = 1'b1;
            if (stat.ptr_at_end) begin
               state_in = S_DN_FLUSH;
            end
         end
         S_DN_FLUSH: begin
            cmd.cnt_dec = 1'b1;
            state_in    = S_FINISH;
         end
         S_RD: begin
            state_in = S_FINISH;
         end
         S_FINISH: begin
            if (!stat.rsp_busy) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      cmd.rsp_status   = status_ff;
      cmd.rsp_use_data = use_data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         status_ff   <= ST_OK;
         use_data_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         status_ff   <= status_in;
         use_data_ff <= use_data_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);

endmodule

FILE: design/ilst_dp.sv
module ilst_dp import ilst_pkg::*; #(
   parameter int DEPTH = 256
) (
   input  logic                    clock,
   input  logic                    reset,
   input  ilst_cmd_type            cmd,
   output ilst_stat_type           stat,
   input  logic [MODE_W-1:0]       req_mode,
   input  logic [POS_W-1:0]        req_position,
   input  logic signed [VAL_W-1:0] req_value_in,
   input  logic                    rsp_ready,
   output logic                    rsp_valid,
   output logic signed [VAL_W-1:0] rsp_value_out,
   output logic [STAT_W-1:0]       rsp_status,
   output logic [LEN_W-1:0]        rsp_length
);

   localparam int AW   = $clog2(DEPTH);
   localparam int CW   = $clog2(DEPTH + 1);
   localparam int CMPW = (CW > POS_W) ? CW : POS_W;

   logic [MODE_W-1:0]       mode_ff;
   logic [POS_W-1:0]        pos_ff;
   logic signed [VAL_W-1:0] val_ff;
   logic [CW-1:0]           count_ff, count_in;
   logic [AW-1:0]           ptr_ff, ptr_in;
   logic [AW-1:0]           wr_addr_ff, wr_addr_in;
   logic                    wr_pend_ff, wr_pend_in;
   logic signed [VAL_W-1:0] rd_data_ff;
   logic signed [VAL_W-1:0] mem [DEPTH];
   logic                    rsp_valid_ff, rsp_valid_in;
   logic signed [VAL_W-1:0] value_out_ff;
   logic [STAT_W-1:0]       status_ff;
   logic [LEN_W-1:0]        length_ff;

   logic [CMPW-1:0] pos_ext, cnt_ext;
   logic            beyond, shifting, rd_en;
   logic [AW-1:0]   last_addr, ins_addr, direct_addr, rd_addr;

   always_comb begin
      pos_ext     = CMPW'(pos_ff);
      cnt_ext     = CMPW'(count_ff);
      beyond      = (pos_ext >= cnt_ext);
      last_addr   = AW'(count_ff - CW'(1));
      ins_addr    = beyond ? AW'(count_ff) : AW'(pos_ff);
      direct_addr = beyond ? last_addr : AW'(pos_ff);
      shifting    = cmd.shift_up | cmd.shift_dn;
      rd_en       = shifting | cmd.rd_direct;
      rd_addr     = shifting ? ptr_ff : direct_addr;

      stat.mode       = mode_ff;
      stat.full       = (count_ff == CW'(DEPTH));
      stat.empty      = (count_ff == '0);
      stat.beyond     = beyond;
      stat.last       = (pos_ext == cnt_ext - CMPW'(1));
      stat.ptr_at_pos = (ptr_ff == AW'(pos_ff));
      stat.ptr_at_end = (ptr_ff == last_addr);
      stat.rsp_busy   = rsp_valid_ff & ~rsp_ready;

      if (cmd.ptr_load_up) begin
         ptr_in = last_addr;
      end else if (cmd.ptr_load_dn) begin
         ptr_in = AW'(pos_ff) + AW'(1);
      end else if (cmd.shift_up) begin
         ptr_in = ptr_ff - AW'(1);
      end else if (cmd.shift_dn) begin
         ptr_in = ptr_ff + AW'(1);
      end else begin
         ptr_in = ptr_ff;
      end

      wr_pend_in = shifting;
      wr_addr_in = cmd.shift_up ? ptr_ff + AW'(1) : ptr_ff - AW'(1);

      if (cmd.cnt_inc) begin
         count_in = count_ff + CW'(1);
      end else if (cmd.cnt_dec) begin
         count_in = count_ff - CW'(1);
      end else begin
         count_in = count_ff;
      end

      rsp_valid_in = cmd.rsp_load | (rsp_valid_ff & ~rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         wr_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         wr_pend_ff   <= wr_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff     <= ptr_in;
      wr_addr_ff <= wr_addr_in;
      if (cmd.accept) begin
         mode_ff <= req_mode;
         pos_ff  <= req_position;
         val_ff  <= req_value_in;
      end
      if (cmd.rsp_load) begin
         value_out_ff <= cmd.rsp_use_data ? rd_data_ff : '0;
         status_ff    <= cmd.rsp_status;
         length_ff    <= LEN_W'(count_ff);
      end
   end

   // One write port: a delayed shift write, or the new element.
   always_ff @(posedge clock) begin
      if (wr_pend_ff) begin
         mem[wr_addr_ff] <= rd_data_ff;
      end else if (cmd.put) begin
         mem[ins_addr] <= val_ff;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_value_out = value_out_ff;
   assign rsp_status    = status_ff;
   assign rsp_length    = length_ff;

endmodule

FILE: design/indexed_list_insert_delete_read_unit.sv
// Insert inside the list and delete before the last element shift the tail of the list
// that starts at the position; append, delete of the last element, read and errors shift none.
// One item at a time: the next request beat is taken once the response is registered,
// also while that response beat is stalled; the next response then waits for it.
// The single-write-port memory moves one element per cycle in a shift. Synchronous
// active-high reset empties the list and clears the response, not the element memory.
module indexed_list_insert_delete_read_unit import ilst_pkg::*; #(
   parameter int DEPTH = 256
) (
   input logic        clock,
   input logic        reset,
   ilst_req_if.sink   req_chan,
   ilst_rsp_if.source rsp_chan
);

   ilst_cmd_type  cmd;
   ilst_stat_type stat;
   logic          req_ready;
   logic          rsp_valid;

   ilst_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   ilst_dp #(
      .DEPTH (DEPTH)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .stat          (stat),
      .req_mode      (req_chan.mode),
      .req_position  (req_chan.position),
      .req_value_in  (req_chan.value_in),
      .rsp_ready     (rsp_chan.ready),
      .rsp_valid     (rsp_valid),
      .rsp_value_out (rsp_chan.value_out),
      .rsp_status    (rsp_chan.status),
      .rsp_length    (rsp_chan.length)
   );

   assign req_chan.ready = req_ready;
   assign rsp_chan.valid = rsp_valid;

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_chan.valid && req_chan.ready |=> !req_chan.ready)
      else $error("A second request was taken while one is in progress.");

   a_full_length: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.status == ST_FULL |-> rsp_chan.length == LEN_W'(DEPTH))
      else $error("A full-list response does not report the full length.");

   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.status != ST_OK |-> rsp_chan.value_out == '0)
      else $error("An error response carries a non-zero value.");

endmodule
